>>> src/tftp_pkg.sv
package tftp_pkg;
    localparam int SESSIONS_DEF = 16;
    localparam int BLOCK_BYTES_DEF = 512;
    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    localparam logic [15:0] OP_RRQ = 16'd1;
    localparam logic [15:0] OP_WRQ = 16'd2;
    localparam logic [15:0] OP_DATA = 16'd3;
    localparam logic [15:0] OP_ACK = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    localparam logic [1:0] ACT_DATA = 2'd0;
    localparam logic [1:0] ACT_ACK = 2'd1;
    localparam logic [1:0] ACT_ERROR = 2'd2;
    localparam logic [1:0] ACT_CLOSED = 2'd3;

    localparam logic [1:0] KIND_FREE = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } state_t;
endpackage

>>> src/tftp_server_session_engine.sv
// channel   direction  handshake               payload
// s_        in         s_valid / s_ready       request fields, mode selects packet or tick
// m_        out        m_valid / m_ready       one action per result, m_last on the final one
// cfg       in         cfg_we / cfg_wdata      idle timeout in seconds
// a request scans the table one entry per cycle through a shared compare unit,
// then a decision state; results leave one per accepted output cycle,
// and s_ready stays low until the last result of the request is taken.
// a tick scans the table one entry per cycle, stalling while a close result is not taken.
// aresetn is synchronous; it frees every session and sets the timeout to 5.
module tftp_server_session_engine #(
    parameter int SESSIONS = tftp_pkg::SESSIONS_DEF,
    parameter int BLOCK_BYTES = tftp_pkg::BLOCK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic        s_to_main_port,
    input  logic [31:0] s_client_ip,
    input  logic [15:0] s_client_port,
    input  logic [15:0] s_opcode,
    input  logic [15:0] s_block_number,
    input  logic [9:0]  s_packet_length,
    input  logic        s_file_ok,
    input  logic [9:0]  s_next_data_length,
    input  logic [31:0] s_now_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_session_index,
    output logic [1:0]  m_action,
    output logic [15:0] m_out_block,
    output logic [9:0]  m_out_data_length,
    output logic        m_error_kind,
    output logic        m_via_main_port,
    output logic        m_last
);
    import tftp_pkg::*;

    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int CW = $clog2(SESSIONS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(SESSIONS - 1);
    localparam logic [10:0] BB11 = (BLOCK_BYTES > 1023) ? 11'd1024 : 11'(BLOCK_BYTES);

    state_t state_reg, state_next;

    logic [7:0]  timeout_reg;
    logic [1:0]  kind_reg [SESSIONS];
    logic [31:0] addr_reg [SESSIONS];
    logic [15:0] port_reg [SESSIONS];
    logic [15:0] blk_reg [SESSIONS];
    logic [9:0]  len_reg [SESSIONS];
    logic [31:0] time_reg [SESSIONS];

    logic        main_reg, fok_reg;
    logic [31:0] ip_reg, now_reg;
    logic [15:0] cport_reg, op_reg, bn_reg;
    logic [9:0]  plen_reg, nlen_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next, free_reg, free_next;
    logic [IW-1:0] hidx_reg, hidx_next, fidx_reg, fidx_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [1:0]    nres_reg, nres_next;
    logic [1:0]    ridx_reg, ridx_next;

    logic [3:0]  r0_idx, r1_idx;
    logic [1:0]  r0_act, r1_act;
    logic [15:0] r0_blk_reg;
    logic [9:0]  r0_len_reg;
    logic        r0_err_reg, r0_main_reg;
    logic [3:0]  ridx_s_reg;
    logic [1:0]  r0_act_reg;

    logic [IW-1:0] cur;
    logic          match, expired;
    logic [9:0]    nlen_c;

    assign cur = idx_reg[IW-1:0];
    assign match = (kind_reg[cur] != KIND_FREE) && (addr_reg[cur] == ip_reg)
        && (port_reg[cur] == cport_reg);
    assign expired = (kind_reg[cur] != KIND_FREE)
        && ((now_reg - time_reg[cur]) > {24'd0, timeout_reg});
    assign nlen_c = ({1'b0, s_next_data_length} < BB11) ? s_next_data_length : BB11[9:0];

    // decision over the located session
    logic [IW-1:0] hs;
    logic [1:0]    hk;
    logic [15:0]   hb, hb1;
    logic [9:0]    hl;
    logic          dec_write;
    logic [1:0]    dec_kind;
    logic [15:0]   dec_blk;
    logic [9:0]    dec_len;
    logic          dec_time;
    logic [1:0]    dec_n;
    logic [1:0]    a0;
    logic [15:0]   b0;
    logic [9:0]    l0;
    logic          e0, mp0;
    logic [3:0]    i0;
    logic          is_req, do_open;
    logic [IW-1:0] wsel;

    assign hs = hidx_reg;
    assign hk = kind_reg[hs];
    assign hb = blk_reg[hs];
    assign hb1 = hb + 16'd1;
    assign hl = len_reg[hs];
    assign is_req = (op_reg == OP_RRQ) || (op_reg == OP_WRQ);

    always_comb begin
        dec_write = 1'b0;
        dec_kind = hk;
        dec_blk = hb;
        dec_len = hl;
        dec_time = 1'b0;
        dec_n = 2'd0;
        a0 = ACT_CLOSED;
        b0 = 16'd0;
        l0 = 10'd0;
        e0 = 1'b0;
        mp0 = 1'b0;
        i0 = 4'(hs);
        do_open = 1'b0;
        wsel = hs;
        if (main_reg) begin
            i0 = 4'd0;
            if (is_req) begin
                if (!hit_reg) begin
                    dec_n = 2'd1;
                    if (!free_reg) begin
                        a0 = ACT_ERROR;
                        mp0 = 1'b1;
                    end else if (!fok_reg) begin
                        a0 = ACT_CLOSED;
                        i0 = 4'(fidx_reg);
                    end else begin
                        do_open = 1'b1;
                        wsel = fidx_reg;
                        i0 = 4'(fidx_reg);
                        dec_write = 1'b1;
                        dec_time = 1'b1;
                        if (op_reg == OP_RRQ) begin
                            dec_kind = KIND_READ;
                            dec_blk = 16'd1;
                            dec_len = nlen_reg;
                            a0 = ACT_DATA;
                            b0 = 16'd1;
                            l0 = nlen_reg;
                        end else begin
                            dec_kind = KIND_WRITE;
                            dec_blk = 16'd0;
                            dec_len = 10'd0;
                            a0 = ACT_ACK;
                        end
                    end
                end
            end else begin
                dec_n = 2'd1;
                a0 = ACT_ERROR;
                e0 = 1'b1;
                mp0 = 1'b1;
            end
        end else if (hit_reg) begin
            if (op_reg == OP_DATA) begin
                if (hk != KIND_WRITE) begin
                    dec_n = 2'd1;
                    a0 = ACT_ERROR;
                    e0 = 1'b1;
                end else if (plen_reg >= 10'd4) begin
                    if (bn_reg == hb1) begin
                        dec_write = 1'b1;
                        dec_time = 1'b1;
                        dec_blk = bn_reg;
                        a0 = ACT_ACK;
                        b0 = bn_reg;
                        dec_n = 2'd1;
                        if ({1'b0, plen_reg - 10'd4} < BB11) begin
                            dec_kind = KIND_FREE;
                            dec_n = 2'd2;
                        end
                    end else if (bn_reg == hb) begin
                        dec_n = 2'd1;
                        a0 = ACT_ACK;
                        b0 = bn_reg;
                    end
                end
            end else if (op_reg == OP_ACK) begin
                if (hk != KIND_READ) begin
                    dec_n = 2'd1;
                    a0 = ACT_ERROR;
                    e0 = 1'b1;
                end else if (bn_reg == hb) begin
                    dec_n = 2'd1;
                    dec_write = 1'b1;
                    if ({1'b0, hl} < BB11) begin
                        dec_kind = KIND_FREE;
                    end else begin
                        dec_blk = hb1;
                        dec_len = nlen_reg;
                        dec_time = 1'b1;
                        a0 = ACT_DATA;
                        b0 = hb1;
                        l0 = nlen_reg;
                    end
                end
            end else if (op_reg == OP_ERROR) begin
                dec_n = 2'd1;
                dec_write = 1'b1;
                dec_kind = KIND_FREE;
            end else begin
                dec_n = 2'd1;
                a0 = ACT_ERROR;
                e0 = 1'b1;
            end
        end
    end

    assign r0_idx = ridx_s_reg;
    assign r1_idx = ridx_s_reg;
    assign r0_act = r0_act_reg;
    assign r1_act = ACT_CLOSED;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_mode ? ST_TICK : ST_SCAN;
                end
            end
            ST_TICK: begin
                if (idx_reg > LAST_IDX) begin
                    state_next = ST_IDLE;
                end else if (expired && !(m_valid && !m_ready)) begin
                    state_next = ST_TICK;
                end
            end
            ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = (dec_n == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready && (ridx_reg + 2'd1 == nres_reg)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // counters and flags
    always_comb begin
        idx_next = idx_reg;
        hit_next = hit_reg;
        free_next = free_reg;
        hidx_next = hidx_reg;
        fidx_next = fidx_reg;
        cnt_next = cnt_reg;
        nres_next = nres_reg;
        ridx_next = ridx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                hit_next = 1'b0;
                free_next = 1'b0;
                cnt_next = 4'd0;
                ridx_next = 2'd0;
            end
            ST_TICK: begin
                if (idx_reg <= LAST_IDX && !(m_valid && !m_ready)) begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + CW'(1);
                if (match && !hit_reg) begin
                    hit_next = 1'b1;
                    hidx_next = cur;
                end
                if (kind_reg[cur] == KIND_FREE && !free_reg) begin
                    free_next = 1'b1;
                    fidx_next = cur;
                end
            end
            ST_DECIDE: begin
                nres_next = dec_n;
                ridx_next = 2'd0;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    ridx_next = ridx_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // the tick scan stops after the sixteenth close; m_last must also mark the
    // final close found, so the tick looks ahead over the remaining entries
    logic tick_more;
    always_comb begin
        tick_more = 1'b0;
        for (int j = 0; j < SESSIONS; j++) begin
            if (CW'(j) > idx_reg && kind_reg[j] != KIND_FREE
                && ((now_reg - time_reg[j]) > {24'd0, timeout_reg})) begin
                tick_more = 1'b1;
            end
        end
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = 1'b0;
        m_session_index = r0_idx;
        m_action = r0_act;
        m_out_block = r0_blk_reg;
        m_out_data_length = r0_len_reg;
        m_error_kind = r0_err_reg;
        m_via_main_port = r0_main_reg;
        m_last = 1'b0;
        unique case (state_reg)
            ST_EMIT: begin
                m_valid = 1'b1;
                if (ridx_reg == 2'd1) begin
                    m_session_index = r1_idx;
                    m_action = r1_act;
                    m_out_block = 16'd0;
                end
                m_last = (ridx_reg + 2'd1 == nres_reg);
            end
            ST_TICK: begin
                m_valid = (idx_reg <= LAST_IDX) && expired;
                m_session_index = 4'(cur);
                m_action = ACT_CLOSED;
                m_out_block = 16'd0;
                m_out_data_length = 10'd0;
                m_error_kind = 1'b0;
                m_via_main_port = 1'b0;
                m_last = (cnt_reg == 4'd15) || !tick_more;
            end
            default: ;
        endcase
    end

    logic tick_fire, tick_end;
    assign tick_fire = (state_reg == ST_TICK) && m_valid && m_ready;
    assign tick_end = tick_fire && (!tick_more || cnt_reg == 4'd15);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            timeout_reg <= TIMEOUT_RESET;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            cnt_reg <= 4'd0;
            nres_reg <= 2'd0;
            ridx_reg <= 2'd0;
            for (int j = 0; j < SESSIONS; j++) begin
                kind_reg[j] <= KIND_FREE;
            end
        end else begin
            state_reg <= tick_end ? ST_IDLE : state_next;
            idx_reg <= idx_next;
            hit_reg <= hit_next;
            free_reg <= free_next;
            hidx_reg <= hidx_next;
            fidx_reg <= fidx_next;
            cnt_reg <= tick_fire ? cnt_reg + 4'd1 : cnt_next;
            nres_reg <= nres_next;
            ridx_reg <= ridx_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (tick_fire) begin
                kind_reg[cur] <= KIND_FREE;
            end
            if (state_reg == ST_DECIDE && dec_write) begin
                kind_reg[wsel] <= dec_kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            main_reg <= s_to_main_port;
            ip_reg <= s_client_ip;
            cport_reg <= s_client_port;
            op_reg <= s_opcode;
            bn_reg <= s_block_number;
            plen_reg <= s_packet_length;
            fok_reg <= s_file_ok;
            nlen_reg <= nlen_c;
            now_reg <= s_now_seconds;
        end
        if (state_reg == ST_DECIDE) begin
            ridx_s_reg <= i0;
            r0_act_reg <= a0;
            r0_blk_reg <= b0;
            r0_len_reg <= l0;
            r0_err_reg <= e0;
            r0_main_reg <= mp0;
            if (dec_write) begin
                blk_reg[wsel] <= dec_blk;
                len_reg[wsel] <= dec_len;
                if (dec_time) begin
                    time_reg[wsel] <= now_reg;
                end
                if (do_open) begin
                    addr_reg[wsel] <= ip_reg;
                    port_reg[wsel] <= cport_reg;
                end
            end
        end
        if (state_reg == ST_EMIT && m_ready && ridx_reg == 2'd0) begin
            r0_blk_reg <= 16'd0;
            r0_len_reg <= 10'd0;
            r0_err_reg <= 1'b0;
            r0_main_reg <= 1'b0;
        end
    end
endmodule

>>> dv/tb_tftp_server_session_engine.sv
`timescale 1ns / 1ps

module tb_tftp_server_session_engine;
    import tftp_pkg::*;

    typedef struct {
        logic        mode;
        logic        mainp;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] op;
        logic [15:0] blk;
        logic [9:0]  plen;
        logic        fok;
        logic [9:0]  nlen;
        logic [31:0] now;
    } request_t;

    typedef struct {
        logic [3:0]  idx;
        logic [1:0]  act;
        logic [15:0] blk;
        logic [9:0]  len;
        logic        err;
        logic        mainp;
        logic        last;
    } action_t;

    typedef struct {
        request_t rq;
        bit       typed;
        action_t  act;
    } row_t;

    localparam int LIMIT = 600000;
    localparam int POOL  = 24;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [7:0]  cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_mode = 0;
    logic        s_to_main_port = 0;
    logic [31:0] s_client_ip = 0;
    logic [15:0] s_client_port = 0;
    logic [15:0] s_opcode = 0;
    logic [15:0] s_block_number = 0;
    logic [9:0]  s_packet_length = 0;
    logic        s_file_ok = 0;
    logic [9:0]  s_next_data_length = 0;
    logic [31:0] s_now_seconds = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [3:0]  m_session_index;
    logic [1:0]  m_action;
    logic [15:0] m_out_block;
    logic [9:0]  m_out_data_length;
    logic        m_error_kind;
    logic        m_via_main_port;
    logic        m_last;

    tftp_server_session_engine u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_to_main_port(s_to_main_port), .s_client_ip(s_client_ip),
        .s_client_port(s_client_port), .s_opcode(s_opcode),
        .s_block_number(s_block_number), .s_packet_length(s_packet_length),
        .s_file_ok(s_file_ok), .s_next_data_length(s_next_data_length),
        .s_now_seconds(s_now_seconds), .m_valid(m_valid), .m_ready(m_ready),
        .m_session_index(m_session_index), .m_action(m_action),
        .m_out_block(m_out_block), .m_out_data_length(m_out_data_length),
        .m_error_kind(m_error_kind), .m_via_main_port(m_via_main_port),
        .m_last(m_last)
    );

    always #4 aclk = ~aclk;

    // session table mirror
    logic [1:0]  sess_kind [16];
    logic [31:0] sess_addr [16];
    logic [15:0] sess_port [16];
    logic [15:0] sess_blk  [16];
    logic [9:0]  sess_len  [16];
    logic [31:0] sess_seen [16];
    logic [7:0]  idle_limit;

    action_t     pending_actions [$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          phase = -1;
    int          accepted = 0;
    int          cycles = 0;
    logic [31:0] clock_s = 100;
    logic [31:0] pool_ip [POOL];
    logic [15:0] pool_port [POOL];

    function automatic void add_action(ref action_t q[$], input int idx, input logic [1:0] act,
                                       input logic [15:0] blk, input logic [9:0] len,
                                       input logic err, input logic mainp);
        action_t a;
        if (q.size() >= 16) return;
        a.idx = idx[3:0];
        a.act = act;
        a.blk = blk;
        a.len = len;
        a.err = err;
        a.mainp = mainp;
        a.last = 0;
        q.push_back(a);
    endfunction

    function automatic int find_session(logic [31:0] ip, logic [15:0] port);
        for (int i = 0; i < 16; i++)
            if (sess_kind[i] != KIND_FREE && sess_addr[i] == ip && sess_port[i] == port)
                return i;
        return -1;
    endfunction

    function automatic void session_step(request_t rq, ref action_t q[$]);
        logic [9:0]  nlen;
        logic [15:0] nxt;
        int          s;
        nlen = (rq.nlen > 10'd512) ? 10'd512 : rq.nlen;
        q.delete();
        if (rq.mode) begin
            for (int i = 0; i < 16; i++)
                if (q.size() < 16 && sess_kind[i] != KIND_FREE &&
                    (rq.now - sess_seen[i]) > {24'd0, idle_limit}) begin
                    sess_kind[i] = KIND_FREE;
                    add_action(q, i, ACT_CLOSED, 0, 0, 0, 0);
                end
        end else if (rq.mainp) begin
            if (rq.op == OP_RRQ || rq.op == OP_WRQ) begin
                if (find_session(rq.ip, rq.port) < 0) begin
                    s = -1;
                    for (int i = 0; i < 16; i++)
                        if (s < 0 && sess_kind[i] == KIND_FREE) s = i;
                    if (s < 0) begin
                        add_action(q, 0, ACT_ERROR, 0, 0, 0, 1);
                    end else if (!rq.fok) begin
                        add_action(q, s, ACT_CLOSED, 0, 0, 0, 0);
                    end else begin
                        sess_addr[s] = rq.ip;
                        sess_port[s] = rq.port;
                        sess_seen[s] = rq.now;
                        if (rq.op == OP_RRQ) begin
                            sess_kind[s] = KIND_READ;
                            sess_blk[s] = 1;
                            sess_len[s] = nlen;
                            add_action(q, s, ACT_DATA, 1, nlen, 0, 0);
                        end else begin
                            sess_kind[s] = KIND_WRITE;
                            sess_blk[s] = 0;
                            sess_len[s] = 0;
                            add_action(q, s, ACT_ACK, 0, 0, 0, 0);
                        end
                    end
                end
            end else begin
                add_action(q, 0, ACT_ERROR, 0, 0, 1, 1);
            end
        end else begin
            s = find_session(rq.ip, rq.port);
            if (s >= 0) begin
                if (rq.op == OP_DATA) begin
                    if (sess_kind[s] != KIND_WRITE) begin
                        add_action(q, s, ACT_ERROR, 0, 0, 1, 0);
                    end else if (rq.plen >= 4) begin
                        nxt = sess_blk[s] + 16'd1;
                        if (rq.blk == nxt) begin
                            sess_blk[s] = rq.blk;
                            sess_seen[s] = rq.now;
                            add_action(q, s, ACT_ACK, rq.blk, 0, 0, 0);
                            if (rq.plen - 10'd4 < 10'd512) begin
                                sess_kind[s] = KIND_FREE;
                                add_action(q, s, ACT_CLOSED, 0, 0, 0, 0);
                            end
                        end else if (rq.blk == sess_blk[s]) begin
                            add_action(q, s, ACT_ACK, rq.blk, 0, 0, 0);
                        end
                    end
                end else if (rq.op == OP_ACK) begin
                    if (sess_kind[s] != KIND_READ) begin
                        add_action(q, s, ACT_ERROR, 0, 0, 1, 0);
                    end else if (rq.blk == sess_blk[s]) begin
                        if (sess_len[s] < 10'd512) begin
                            sess_kind[s] = KIND_FREE;
                            add_action(q, s, ACT_CLOSED, 0, 0, 0, 0);
                        end else begin
                            sess_blk[s] = sess_blk[s] + 16'd1;
                            sess_len[s] = nlen;
                            sess_seen[s] = rq.now;
                            add_action(q, s, ACT_DATA, sess_blk[s], nlen, 0, 0);
                        end
                    end
                end else if (rq.op == OP_ERROR) begin
                    sess_kind[s] = KIND_FREE;
                    add_action(q, s, ACT_CLOSED, 0, 0, 0, 0);
                end else begin
                    add_action(q, s, ACT_ERROR, 0, 0, 1, 0);
                end
            end
        end
        if (q.size() > 0) q[q.size() - 1].last = 1;
    endfunction

    // returns number of actions the request caused
    task automatic send_request(request_t rq, bit typed, action_t typed_act, output int n);
        action_t q[$];
        bit      rdy;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_mode <= rq.mode;
        s_to_main_port <= rq.mainp;
        s_client_ip <= rq.ip;
        s_client_port <= rq.port;
        s_opcode <= rq.op;
        s_block_number <= rq.blk;
        s_packet_length <= rq.plen;
        s_file_ok <= rq.fok;
        s_next_data_length <= rq.nlen;
        s_now_seconds <= rq.now;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        accepted++;
        session_step(rq, q);
        if (typed) begin
            q.delete();
            q.push_back(typed_act);
        end
        foreach (q[i]) pending_actions.push_back(q[i]);
        n = q.size();
    endtask

    task automatic drain_and_configure(logic [7:0] value);
        s_valid <= 0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 0;
        idle_limit = value;
    endtask

    function automatic request_t blank(logic [31:0] now);
        request_t rq;
        rq.mode = 0; rq.mainp = 0; rq.ip = 0; rq.port = 0; rq.op = 0; rq.blk = 0;
        rq.plen = 10'd516; rq.fok = 1; rq.nlen = 10'd512; rq.now = now;
        return rq;
    endfunction

    function automatic row_t pkt(logic mainp, int client, logic [15:0] op, logic [15:0] blk,
                                 logic [9:0] plen, logic fok, logic [9:0] nlen);
        row_t r;
        r.rq = blank(100);
        r.rq.mainp = mainp;
        r.rq.ip = 32'h0A000000 + client;
        r.rq.port = 16'd2000 + client[15:0];
        r.rq.op = op;
        r.rq.blk = blk;
        r.rq.plen = plen;
        r.rq.fok = fok;
        r.rq.nlen = nlen;
        r.typed = 0;
        r.act = '{default: 0};
        return r;
    endfunction

    function automatic row_t unsupported_on_main(logic [15:0] op);
        row_t r;
        r = pkt(1, 9, op, 0, 4, 1, 0);
        r.typed = 1;
        r.act = '{idx: 0, act: ACT_ERROR, blk: 0, len: 0, err: 1, mainp: 1, last: 1};
        return r;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int       c;
        int       s;
        int       w;
        rq = blank(clock_s);
        c = $urandom_range(POOL - 1);
        rq.ip = pool_ip[c];
        rq.port = pool_port[c];
        rq.nlen = ($urandom_range(3) == 0) ? 10'($urandom_range(511)) : 10'd512;
        w = $urandom_range(99);
        if (w < 10) begin
            rq.mode = 1;
            rq.now = clock_s + $urandom_range(8);
        end else if (w < 32) begin
            rq.mainp = 1;
            rq.op = $urandom_range(1) ? OP_RRQ : OP_WRQ;
            rq.fok = ($urandom_range(9) != 0);
        end else if (w < 78) begin
            s = find_session(rq.ip, rq.port);
            rq.plen = ($urandom_range(4) == 0) ? 10'($urandom_range(515)) : 10'd516;
            if (s < 0 || $urandom_range(19) == 0) begin
                rq.op = $urandom_range(1) ? OP_ERROR : 16'($urandom_range(6));
                rq.blk = 16'($urandom);
            end else if (sess_kind[s] == KIND_READ) begin
                rq.op = ($urandom_range(9) == 0) ? OP_DATA : OP_ACK;
                rq.blk = ($urandom_range(5) == 0) ? 16'($urandom) : sess_blk[s];
            end else begin
                rq.op = ($urandom_range(9) == 0) ? OP_ACK : OP_DATA;
                w = $urandom_range(9);
                rq.blk = (w < 7) ? sess_blk[s] + 16'd1 : (w < 9) ? sess_blk[s] : 16'($urandom);
            end
        end else if (w < 88) begin
            rq.mainp = 1'($urandom_range(1));
            rq.op = 16'($urandom);
            rq.blk = 16'($urandom);
        end else begin
            rq.mode = ($urandom_range(3) == 0);
            rq.mainp = 1'($urandom_range(1));
            rq.ip = $urandom;
            rq.port = 16'($urandom);
            rq.op = 16'($urandom);
            rq.blk = 16'($urandom);
            rq.plen = 10'($urandom_range(516));
            rq.fok = 1'($urandom_range(1));
            rq.nlen = 10'($urandom_range(1023));
            rq.now = $urandom;
        end
        return rq;
    endfunction

    // result checker
    always @(negedge aclk) begin
        action_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected action idx=%0d act=%0d", m_session_index, m_action);
            end else begin
                e = pending_actions.pop_front();
                if (m_session_index !== e.idx || m_action !== e.act || m_out_block !== e.blk ||
                    m_out_data_length !== e.len || m_error_kind !== e.err ||
                    m_via_main_port !== e.mainp || m_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                 e.idx, e.act, e.blk, e.len, e.err, e.mainp, e.last,
                                 m_session_index, m_action, m_out_block, m_out_data_length,
                                 m_error_kind, m_via_main_port, m_last);
                end
            end
        end
    end

    // result receiver, with one long hold-off in the first random phase
    int  hold_left = 0;
    bit  held = 0;
    always @(posedge aclk) begin
        if (!held && phase == 0 && accepted > 40) begin
            held = 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        row_t          rows [$];
        request_t      rq;
        action_t       none;
        int            n;
        int            raw;
        int            idle_set [4];
        int            stall_set [4];
        logic [7:0]    limits [4];

        idle_set = '{0, 65, 0, 24};
        stall_set = '{0, 0, 65, 24};
        limits = '{8'd0, 8'd255, TIMEOUT_RESET, 8'($urandom_range(1, 254))};
        none = '{default: 0};
        idle_limit = TIMEOUT_RESET;
        foreach (sess_kind[i]) sess_kind[i] = KIND_FREE;
        foreach (pool_ip[i]) begin
            pool_ip[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end

        rq = blank(100);
        rq.mode = 1;
        rows.push_back('{rq: rq, typed: 0, act: none});
        rows.push_back(pkt(1, 1, OP_RRQ, 0, 20, 1, 10'd512));
        rows.push_back(pkt(1, 2, OP_WRQ, 0, 20, 1, 10'd0));
        rows.push_back(pkt(1, 1, OP_RRQ, 0, 20, 1, 10'd512));
        rows.push_back(pkt(1, 3, OP_RRQ, 0, 20, 0, 10'd512));
        rows.push_back(unsupported_on_main(16'd0));
        rows.push_back(unsupported_on_main(16'hFFFF));
        rows.push_back(unsupported_on_main(OP_DATA));
        rows.push_back(pkt(0, 1, OP_ACK, 1, 4, 1, 10'd1023));
        rows.push_back(pkt(0, 1, OP_ACK, 7, 4, 1, 10'd512));
        rows.push_back(pkt(0, 1, OP_DATA, 2, 516, 1, 10'd0));
        rows.push_back(pkt(0, 2, OP_ACK, 0, 4, 1, 10'd0));
        rows.push_back(pkt(0, 2, OP_DATA, 1, 3, 1, 10'd0));
        rows.push_back(pkt(0, 2, OP_DATA, 1, 516, 1, 10'd0));
        rows.push_back(pkt(0, 2, OP_DATA, 1, 516, 1, 10'd0));
        rows.push_back(pkt(0, 2, OP_DATA, 5, 516, 1, 10'd0));
        rows.push_back(pkt(0, 2, 16'd9, 0, 4, 1, 10'd0));
        rows.push_back(pkt(0, 7, OP_DATA, 1, 516, 1, 10'd0));
        rows.push_back(pkt(0, 1, OP_ACK, 2, 4, 1, 10'd100));
        rows.push_back(pkt(0, 1, OP_ACK, 3, 4, 1, 10'd0));
        rows.push_back(pkt(0, 2, OP_DATA, 2, 100, 1, 10'd0));
        rows.push_back(pkt(1, 4, OP_WRQ, 0, 20, 1, 10'd0));
        rows.push_back(pkt(0, 4, OP_ERROR, 0, 4, 1, 10'd0));
        rows.push_back(pkt(1, 5, OP_RRQ, 0, 20, 1, 10'd0));
        rq = blank(32'hFFFFFFFF);
        rq.mode = 1;
        rows.push_back('{rq: rq, typed: 0, act: none});

        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].act, n);

        for (int p = 0; p < 4; p++) begin
            drain_and_configure(limits[p]);
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            phase = p;
            raw = 0;
            while (raw < 84) begin
                rq = random_request();
                send_request(rq, 0, none, n);
                raw++;
                clock_s = clock_s + $urandom_range(2);
            end
        end

        s_valid <= 0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_actions.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
src/tftp_pkg.sv
src/tftp_server_session_engine.sv
dv/tb_tftp_server_session_engine.sv
